### design/qsn_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qsn_pkg
// Shared types, constants and helper functions of the quaternion slerp
// pipeline: the arctangent table, the square root step and the pipeline word.
// ----------------------------------------------------------------------------
package qsn_pkg;

  localparam int FRAC_BITS_DEF    = 14;
  localparam int CORDIC_ITERS_DEF = 16;

  localparam int COMP_W = 16;
  localparam int FRAC_W = 17;
  localparam int THR_W  = 15;

  localparam logic [THR_W-1:0]  THR_RESET   = 15'd13107;
  localparam logic [FRAC_W-1:0] T_ONE       = 17'd65536;
  localparam logic [31:0]       ANG_PI      = 32'd3373259426;
  localparam logic [31:0]       ANG_HALF_PI = 32'd1686629713;
  localparam logic [30:0]       ANG_ONE     = 31'd1073741824;
  localparam logic [31:0]       POS_MAX     = 32'd32767;
  localparam logic [31:0]       NEG_MAX     = 32'd32768;
  localparam logic [31:0]       LEN_MIN     = 32'd65536;

  // Arctangent of 2^-i in units of 2^-30 radian.
  localparam logic [31:0] ATAN_TABLE [32] = '{
    32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159, 32'd67021687,
    32'd33543516, 32'd16775851, 32'd8388437, 32'd4194283, 32'd2097149,
    32'd1048576, 32'd524288, 32'd262144, 32'd131072, 32'd65536, 32'd32768,
    32'd16384, 32'd8192, 32'd4096, 32'd2048, 32'd1024, 32'd512, 32'd256,
    32'd128, 32'd64, 32'd32, 32'd16, 32'd8, 32'd4, 32'd2, 32'd1, 32'd0
  };

  typedef struct packed {
    logic [63:0] n;
    logic [63:0] r;
  } sq_t;

  // One step of the digit-by-digit square root for the trial bit 2^e.
  function automatic sq_t sqrt_step(input logic [63:0] n, input logic [63:0] r,
                                    input int e);
    logic [63:0] bv;
    sq_t         res;
    bv = 64'd1 << e;
    if (n >= r + bv) begin
      res.n = n - (r + bv);
      res.r = (r >> 1) + bv;
    end else begin
      res.n = n;
      res.r = r >> 1;
    end
    return res;
  endfunction

  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    sq_t acc;
    acc.n = v;
    acc.r = 64'd0;
    for (int e = 31; e >= 0; e--) begin
      acc = sqrt_step(acc.n, acc.r, 2 * e);
    end
    return acc.r;
  endfunction

  // Gain of the rotation CORDIC in units of 2^-30.
  function automatic logic [63:0] cordic_gain(input int iters);
    logic [63:0] g;
    logic [63:0] f;
    logic [63:0] add;
    g = 64'd1 << 30;
    for (int i = 0; i < iters; i++) begin
      add = (i <= 30) ? (64'd1 << (60 - 2 * i)) : 64'd0;
      f   = isqrt64((64'd1 << 60) + add);
      g   = (g * f) >> 30;
    end
    return g;
  endfunction

  // Pipeline word. Each stage fills the fields that it computes.
  typedef struct packed {
    logic [3:0][15:0] a;
    logic [3:0][15:0] b;
    logic [16:0]      f;
    logic [3:0][31:0] p;
    logic             slerp;
    logic [31:0]      c30;
    logic [63:0]      n;
    logic [63:0]      r;
    logic [30:0]      s;
    logic [34:0]      cx;
    logic [34:0]      cy;
    logic [34:0]      cz;
    logic [31:0]      w;
    logic [1:0][31:0] ang;
    logic [1:0][34:0] rx;
    logic [1:0][34:0] ry;
    logic [1:0][34:0] rz;
    logic [1:0][46:0] dnum;
    logic [1:0][63:0] drem;
    logic [1:0][31:0] dq;
    logic [1:0][31:0] k;
    logic [3:0][48:0] pa;
    logic [3:0][48:0] pb;
    logic [3:0][48:0] v;
    logic [47:0]      m;
    logic [4:0]       sh;
    logic [3:0][30:0] mag;
    logic [3:0]       neg;
    logic [3:0][61:0] sq;
    logic [31:0]      len;
    logic             deg;
    logic [3:0][63:0] onum;
    logic [3:0][63:0] orem;
    logic [3:0][31:0] oq;
    logic [3:0][15:0] ow;
  } pl_t;

endpackage
`default_nettype wire

### design/quaternion_slerp_normalize.sv
`default_nettype none
// Throughput: one word per cycle unless stalled; every stage is a register, so the
// square roots, both CORDICs and the dividers each retire one bit or one step a
// stage. A stall on a valid output word freezes the whole pipeline in place.
// Reset clears all valid bits and sets the threshold thr_q to 13107 (0.8).
// ----------------------------------------------------------------------------
// quaternion_slerp_normalize
// Pipelined spherical interpolation of two Q2.14 quaternions with unit-length
// normalisation of the weighted sum.
// ----------------------------------------------------------------------------
module quaternion_slerp_normalize #(
  parameter int FRAC_BITS    = qsn_pkg::FRAC_BITS_DEF,
  parameter int CORDIC_ITERS = qsn_pkg::CORDIC_ITERS_DEF
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            cfg_valid_i,
  output logic                           cfg_ready_o,
  input  wire  [qsn_pkg::THR_W-1:0]      cfg_data_i,
  input  wire                            in_valid_i,
  output logic                           in_stall_o,
  input  wire  signed [15:0]             a_w_i,
  input  wire  signed [15:0]             a_x_i,
  input  wire  signed [15:0]             a_y_i,
  input  wire  signed [15:0]             a_z_i,
  input  wire  signed [15:0]             b_w_i,
  input  wire  signed [15:0]             b_x_i,
  input  wire  signed [15:0]             b_y_i,
  input  wire  signed [15:0]             b_z_i,
  input  wire  [qsn_pkg::FRAC_W-1:0]     frac_i,
  output logic                           out_valid_o,
  input  wire                            out_stall_i,
  output logic signed [15:0]             out_w_o,
  output logic signed [15:0]             out_x_o,
  output logic signed [15:0]             out_y_o,
  output logic signed [15:0]             out_z_o,
  output logic                           degenerate_o
);
  import qsn_pkg::*;

  localparam int IT  = CORDIC_ITERS;
  localparam int OB  = FRAC_BITS + 1;
  localparam int D_SH = 2 * FRAC_BITS - 30;
  localparam int D_R = (D_SH > 0) ? D_SH : 0;
  localparam int D_L = (D_SH < 0) ? -D_SH : 0;

  localparam int S_DOT = 1;
  localparam int S_U   = 2;
  localparam int S_SQA = 3;
  localparam int S_VPR = S_SQA + 31;
  localparam int S_VEC = S_VPR + 1;
  localparam int S_WCL = S_VEC + IT;
  localparam int S_ANG = S_WCL + 1;
  localparam int S_RPR = S_ANG + 1;
  localparam int S_ROT = S_RPR + 1;
  localparam int S_DPR = S_ROT + IT;
  localparam int S_DIV = S_DPR + 1;
  localparam int S_KSL = S_DIV + 32;
  localparam int S_PRD = S_KSL + 1;
  localparam int S_VSM = S_PRD + 1;
  localparam int S_MAX = S_VSM + 1;
  localparam int S_SH  = S_MAX + 1;
  localparam int S_SHF = S_SH + 1;
  localparam int S_SQR = S_SHF + 1;
  localparam int S_LSM = S_SQR + 1;
  localparam int S_SQB = S_LSM + 1;
  localparam int S_OPR = S_SQB + 32;
  localparam int S_ODV = S_OPR + 1;
  localparam int S_OUT = S_ODV + OB;
  localparam int LAT   = S_OUT + 1;

  // The rotation CORDIC starts from unit length divided by its gain.
  localparam logic [63:0] ROT_GAIN  = cordic_gain(IT);
  localparam logic [63:0] ROT_START = ((64'd1 << 60) + (ROT_GAIN >> 1)) / ROT_GAIN;

  logic [THR_W-1:0] thr_q, thr_d;
  logic [LAT-1:0]   vld_q;
  logic             adv;
  pl_t              st_q [LAT];
  pl_t              st_d [LAT];

  assign cfg_ready_o = 1'b1;
  assign thr_d       = cfg_valid_i ? cfg_data_i : thr_q;
  assign adv         = !(vld_q[LAT-1] && out_stall_i);
  assign in_stall_o  = !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THR_RESET;
      vld_q <= '0;
    end else begin
      thr_q <= thr_d;
      if (adv) begin
        vld_q <= {vld_q[LAT-2:0], in_valid_i};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < LAT; k++) begin
        st_q[k] <= st_d[k];
      end
    end
  end

  // Input stage: component products and the fraction clamped to one.
  always_comb begin
    st_d[0]      = st_q[0];
    st_d[0].a[0] = a_w_i;
    st_d[0].a[1] = a_x_i;
    st_d[0].a[2] = a_y_i;
    st_d[0].a[3] = a_z_i;
    st_d[0].b[0] = b_w_i;
    st_d[0].b[1] = b_x_i;
    st_d[0].b[2] = b_y_i;
    st_d[0].b[3] = b_z_i;
    st_d[0].p[0] = a_w_i * b_w_i;
    st_d[0].p[1] = a_x_i * b_x_i;
    st_d[0].p[2] = a_y_i * b_y_i;
    st_d[0].p[3] = a_z_i * b_z_i;
    st_d[0].f    = (frac_i > T_ONE) ? T_ONE : frac_i;
  end

  // Dot product, rescale to 30 fractional bits and choose the path.
  always_comb begin
    logic signed [33:0] craw;
    logic signed [33:0] absc;
    logic signed [63:0] c64;
    pl_t                pv;
    pv   = st_q[S_DOT-1];
    craw = 34'($signed(pv.p[0])) + 34'($signed(pv.p[1])) +
           34'($signed(pv.p[2])) + 34'($signed(pv.p[3]));
    absc = (craw < 0) ? -craw : craw;
    c64  = (64'(craw) >>> D_R) <<< D_L;
    st_d[S_DOT]       = pv;
    st_d[S_DOT].c30   = c64[31:0];
    st_d[S_DOT].slerp = (64'(absc) <= (64'(thr_q) << FRAC_BITS)) &&
                        (c64 > -(64'sd1 <<< 30)) && (c64 < (64'sd1 <<< 30));
  end

  always_comb begin
    logic signed [63:0] csq;
    pl_t                pv;
    pv  = st_q[S_U-1];
    csq = $signed(pv.c30) * $signed(pv.c30);
    st_d[S_U]   = pv;
    st_d[S_U].n = (64'd1 << 60) - 64'(csq);
    st_d[S_U].r = 64'd0;
  end

  // s = sqrt(1 - c^2), one result bit per stage.
  for (genvar j = 0; j < 31; j++) begin : g_sqa
    localparam int K = S_SQA + j;
    always_comb begin
      sq_t sr;
      sr = sqrt_step(st_q[K-1].n, st_q[K-1].r, 2 * (30 - j));
      st_d[K]   = st_q[K-1];
      st_d[K].n = sr.n;
      st_d[K].r = sr.r;
    end
  end

  // For a negative cosine the vector is turned by a quarter turn first.
  always_comb begin
    pl_t pv;
    pv = st_q[S_VPR-1];
    st_d[S_VPR]   = pv;
    st_d[S_VPR].s = pv.r[30:0];
    if ($signed(pv.c30) < 0) begin
      st_d[S_VPR].cx = 35'(pv.r[30:0]);
      st_d[S_VPR].cy = 35'(-$signed(pv.c30));
      st_d[S_VPR].cz = 35'(ANG_HALF_PI);
    end else begin
      st_d[S_VPR].cx = 35'($signed(pv.c30));
      st_d[S_VPR].cy = 35'(pv.r[30:0]);
      st_d[S_VPR].cz = 35'd0;
    end
  end

  for (genvar i = 0; i < IT; i++) begin : g_vec
    localparam int K = S_VEC + i;
    always_comb begin
      pl_t pv;
      pv = st_q[K-1];
      st_d[K] = pv;
      if ($signed(pv.cy) > 0) begin
        st_d[K].cx = 35'($signed(pv.cx) + ($signed(pv.cy) >>> i));
        st_d[K].cy = 35'($signed(pv.cy) - ($signed(pv.cx) >>> i));
        st_d[K].cz = pv.cz + 35'(ATAN_TABLE[i]);
      end else begin
        st_d[K].cx = 35'($signed(pv.cx) - ($signed(pv.cy) >>> i));
        st_d[K].cy = 35'($signed(pv.cy) + ($signed(pv.cx) >>> i));
        st_d[K].cz = pv.cz - 35'(ATAN_TABLE[i]);
      end
    end
  end

  always_comb begin
    pl_t pv;
    pv = st_q[S_WCL-1];
    st_d[S_WCL] = pv;
    if ($signed(pv.cz) < 0) begin
      st_d[S_WCL].w = 32'd0;
    end else if ($signed(pv.cz) > $signed(35'(ANG_PI))) begin
      st_d[S_WCL].w = ANG_PI;
    end else begin
      st_d[S_WCL].w = pv.cz[31:0];
    end
  end

  always_comb begin
    logic [48:0] t0;
    logic [48:0] t1;
    pl_t         pv;
    pv = st_q[S_ANG-1];
    t0 = 49'(pv.w) * 49'(T_ONE - pv.f);
    t1 = 49'(pv.w) * 49'(pv.f);
    st_d[S_ANG]        = pv;
    st_d[S_ANG].ang[0] = t0[47:16];
    st_d[S_ANG].ang[1] = t1[47:16];
  end

  // Angles above a quarter turn are folded back, the sine being symmetric.
  always_comb begin
    logic [31:0] av;
    pl_t         pv;
    pv = st_q[S_RPR-1];
    st_d[S_RPR] = pv;
    for (int l = 0; l < 2; l++) begin
      av = pv.ang[l];
      if (av > ANG_HALF_PI) begin
        av = ANG_PI - av;
      end
      st_d[S_RPR].rz[l] = 35'(av);
      st_d[S_RPR].rx[l] = ROT_START[34:0];
      st_d[S_RPR].ry[l] = 35'd0;
    end
  end

  for (genvar i = 0; i < IT; i++) begin : g_rot
    localparam int K = S_ROT + i;
    always_comb begin
      pl_t pv;
      pv = st_q[K-1];
      st_d[K] = pv;
      for (int l = 0; l < 2; l++) begin
        if ($signed(pv.rz[l]) >= 0) begin
          st_d[K].rx[l] = 35'($signed(pv.rx[l]) - ($signed(pv.ry[l]) >>> i));
          st_d[K].ry[l] = 35'($signed(pv.ry[l]) + ($signed(pv.rx[l]) >>> i));
          st_d[K].rz[l] = pv.rz[l] - 35'(ATAN_TABLE[i]);
        end else begin
          st_d[K].rx[l] = 35'($signed(pv.rx[l]) + ($signed(pv.ry[l]) >>> i));
          st_d[K].ry[l] = 35'($signed(pv.ry[l]) - ($signed(pv.rx[l]) >>> i));
          st_d[K].rz[l] = pv.rz[l] + 35'(ATAN_TABLE[i]);
        end
      end
    end
  end

  // The quotient of sin/s stays below 2^32, so the upper dividend bits
  // start the remainder.
  always_comb begin
    logic [30:0] sn;
    pl_t         pv;
    pv = st_q[S_DPR-1];
    st_d[S_DPR] = pv;
    for (int l = 0; l < 2; l++) begin
      if ($signed(pv.ry[l]) < 0) begin
        sn = 31'd0;
      end else if ($signed(pv.ry[l]) > $signed(35'(ANG_ONE))) begin
        sn = ANG_ONE;
      end else begin
        sn = pv.ry[l][30:0];
      end
      st_d[S_DPR].dnum[l] = {sn, 16'd0};
      st_d[S_DPR].drem[l] = 64'({sn, 16'd0} >> 32);
      st_d[S_DPR].dq[l]   = 32'd0;
    end
  end

  for (genvar j = 0; j < 32; j++) begin : g_div
    localparam int K = S_DIV + j;
    localparam int B = 31 - j;
    always_comb begin
      logic [63:0] r2;
      pl_t         pv;
      pv = st_q[K-1];
      st_d[K] = pv;
      for (int l = 0; l < 2; l++) begin
        r2 = {pv.drem[l][62:0], pv.dnum[l][B]};
        if (r2 >= 64'(pv.s)) begin
          st_d[K].drem[l]  = r2 - 64'(pv.s);
          st_d[K].dq[l][B] = 1'b1;
        end else begin
          st_d[K].drem[l] = r2;
        end
      end
    end
  end

  always_comb begin
    pl_t pv;
    pv = st_q[S_KSL-1];
    st_d[S_KSL] = pv;
    if (pv.slerp) begin
      st_d[S_KSL].k = pv.dq;
    end else begin
      st_d[S_KSL].k[0] = 32'(T_ONE - pv.f);
      st_d[S_KSL].k[1] = 32'(pv.f);
    end
  end

  always_comb begin
    pl_t pv;
    pv = st_q[S_PRD-1];
    st_d[S_PRD] = pv;
    for (int i = 0; i < 4; i++) begin
      st_d[S_PRD].pa[i] = $signed({1'b0, pv.k[0]}) * $signed(pv.a[i]);
      st_d[S_PRD].pb[i] = $signed({1'b0, pv.k[1]}) * $signed(pv.b[i]);
    end
  end

  always_comb begin
    pl_t pv;
    pv = st_q[S_VSM-1];
    st_d[S_VSM] = pv;
    for (int i = 0; i < 4; i++) begin
      st_d[S_VSM].v[i] = 49'($signed(pv.pa[i]) + $signed(pv.pb[i]));
    end
  end

  always_comb begin
    logic [3:0][47:0] mg;
    logic [47:0]      m01;
    logic [47:0]      m23;
    pl_t              pv;
    pv = st_q[S_MAX-1];
    for (int i = 0; i < 4; i++) begin
      mg[i] = ($signed(pv.v[i]) < 0) ? 48'(-$signed(pv.v[i])) : pv.v[i][47:0];
    end
    m01 = (mg[0] > mg[1]) ? mg[0] : mg[1];
    m23 = (mg[2] > mg[3]) ? mg[2] : mg[3];
    st_d[S_MAX]   = pv;
    st_d[S_MAX].m = (m01 > m23) ? m01 : m23;
  end

  // Least shift that brings the largest magnitude below 2^30.
  always_comb begin
    pl_t pv;
    pv = st_q[S_SH-1];
    st_d[S_SH]    = pv;
    st_d[S_SH].sh = 5'd0;
    for (int b = 30; b < 48; b++) begin
      if (pv.m[b]) begin
        st_d[S_SH].sh = 5'(b - 29);
      end
    end
  end

  always_comb begin
    logic signed [48:0] vs;
    pl_t                pv;
    pv = st_q[S_SHF-1];
    st_d[S_SHF] = pv;
    for (int i = 0; i < 4; i++) begin
      vs = $signed(pv.v[i]) >>> pv.sh;
      st_d[S_SHF].neg[i] = (vs < 0);
      st_d[S_SHF].mag[i] = (vs < 0) ? 31'(-vs) : 31'(vs);
    end
  end

  always_comb begin
    pl_t pv;
    pv = st_q[S_SQR-1];
    st_d[S_SQR] = pv;
    for (int i = 0; i < 4; i++) begin
      st_d[S_SQR].sq[i] = pv.mag[i] * pv.mag[i];
    end
  end

  always_comb begin
    pl_t pv;
    pv = st_q[S_LSM-1];
    st_d[S_LSM]   = pv;
    st_d[S_LSM].n = 64'(pv.sq[0]) + 64'(pv.sq[1]) + 64'(pv.sq[2]) + 64'(pv.sq[3]);
    st_d[S_LSM].r = 64'd0;
  end

  for (genvar j = 0; j < 32; j++) begin : g_sqb
    localparam int K = S_SQB + j;
    always_comb begin
      sq_t sr;
      sr = sqrt_step(st_q[K-1].n, st_q[K-1].r, 2 * (31 - j));
      st_d[K]   = st_q[K-1];
      st_d[K].n = sr.n;
      st_d[K].r = sr.r;
    end
  end

  // Each magnitude is at most the length, so the quotient fits OB bits.
  always_comb begin
    pl_t pv;
    pv = st_q[S_OPR-1];
    st_d[S_OPR]     = pv;
    st_d[S_OPR].len = pv.r[31:0];
    st_d[S_OPR].deg = (pv.sh == 5'd0) && (pv.r[31:0] < LEN_MIN);
    for (int i = 0; i < 4; i++) begin
      st_d[S_OPR].onum[i] = (64'(pv.mag[i]) << FRAC_BITS) + 64'(pv.r[31:1]);
      st_d[S_OPR].orem[i] = ((64'(pv.mag[i]) << FRAC_BITS) + 64'(pv.r[31:1])) >> OB;
      st_d[S_OPR].oq[i]   = 32'd0;
    end
  end

  for (genvar j = 0; j < OB; j++) begin : g_odv
    localparam int K = S_ODV + j;
    localparam int B = OB - 1 - j;
    always_comb begin
      logic [63:0] r2;
      pl_t         pv;
      pv = st_q[K-1];
      st_d[K] = pv;
      for (int i = 0; i < 4; i++) begin
        r2 = {pv.orem[i][62:0], pv.onum[i][B]};
        if (r2 >= 64'(pv.len)) begin
          st_d[K].orem[i]  = r2 - 64'(pv.len);
          st_d[K].oq[i][B] = 1'b1;
        end else begin
          st_d[K].orem[i] = r2;
        end
      end
    end
  end

  always_comb begin
    pl_t pv;
    pv = st_q[S_OUT-1];
    st_d[S_OUT] = pv;
    for (int i = 0; i < 4; i++) begin
      if (pv.deg) begin
        st_d[S_OUT].ow[i] = 16'd0;
      end else if (pv.neg[i]) begin
        st_d[S_OUT].ow[i] = (pv.oq[i] > NEG_MAX) ? 16'h8000 : 16'(32'd0 - pv.oq[i]);
      end else begin
        st_d[S_OUT].ow[i] = (pv.oq[i] > POS_MAX) ? 16'h7fff : pv.oq[i][15:0];
      end
    end
  end

  assign out_valid_o  = vld_q[LAT-1];
  assign out_w_o      = st_q[S_OUT].ow[0];
  assign out_x_o      = st_q[S_OUT].ow[1];
  assign out_y_o      = st_q[S_OUT].ow[2];
  assign out_z_o      = st_q[S_OUT].ow[3];
  assign degenerate_o = st_q[S_OUT].deg;

  a_deg_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && degenerate_o |->
      (out_w_o == 16'sd0) && (out_x_o == 16'sd0) && (out_y_o == 16'sd0) &&
      (out_z_o == 16'sd0))
    else $error("degenerate word with non-zero components");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |=> $stable(vld_q))
    else $error("pipeline moved while stalled");

  a_lin_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[S_KSL] && !st_q[S_KSL].slerp |->
      (33'(st_q[S_KSL].k[0]) + 33'(st_q[S_KSL].k[1]) == 33'(T_ONE)))
    else $error("linear weights do not sum to one");

  a_len_nz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[S_OPR] && !st_q[S_OPR].deg |-> (st_q[S_OPR].len != 32'd0))
    else $error("division by a zero length");

endmodule
`default_nettype wire

### sim/quaternion_slerp_normalize_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// quaternion_slerp_normalize_tb
// Self-checking bench for the slerp normaliser. Random and directed quaternion
// pairs are pushed through the pipeline while both handshakes idle at random.
// A bit-exact integer predictor computes the expected unit quaternion of each
// word, and a small scoreboard compares the results in order.
// ----------------------------------------------------------------------------
module quaternion_slerp_normalize_tb;
  import qsn_pkg::*;

  localparam int LATENCY   = 160;
  localparam int WDOG_MAX  = 20000;
  localparam int N_RANDOM  = 1200;
  localparam int N_QUIET   = 300;

  typedef struct {
    logic signed [15:0] w, x, y, z;
    logic               deg;
  } quat_res_t;

  // Constants of the angle arithmetic, in units of 2^-30.
  localparam longint PI_Q30   = 64'sd3373259426;
  localparam longint HPI_Q30  = 64'sd1686629713;
  localparam longint ONE_Q30  = 64'sd1073741824;

  localparam longint ATAN_Q30 [16] = '{
    843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
    16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
    65536, 32768
  };

  function automatic longint shr_floor(input longint v, input int s);
    return v >>> s;
  endfunction

  function automatic longint unsigned int_root(input longint unsigned n);
    longint unsigned acc, bitv;
    acc  = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= acc + bitv) begin
        n   = n - (acc + bitv);
        acc = (acc >> 1) + bitv;
      end else begin
        acc = acc >> 1;
      end
      bitv >>= 2;
    end
    return acc;
  endfunction

  function automatic longint gain_inverse();
    longint unsigned g, fct, add;
    g = 64'd1 << 30;
    for (int i = 0; i < 16; i++) begin
      add = 64'd1 << (60 - 2 * i);
      fct = int_root((64'd1 << 60) + add);
      g   = (g * fct) >> 30;
    end
    return longint'(((64'd1 << 60) + g / 2) / g);
  endfunction

  function automatic longint vector_angle(input longint s, input longint c);
    longint x, y, z, nx, ny;
    x = c; y = s; z = 0;
    if (c < 0) begin
      x = s; y = -c; z = HPI_Q30;
    end
    for (int i = 0; i < 16; i++) begin
      if (y > 0) begin
        nx = x + shr_floor(y, i); ny = y - shr_floor(x, i); z += ATAN_Q30[i];
      end else begin
        nx = x - shr_floor(y, i); ny = y + shr_floor(x, i); z -= ATAN_Q30[i];
      end
      x = nx; y = ny;
    end
    if (z < 0) z = 0;
    if (z > PI_Q30) z = PI_Q30;
    return z;
  endfunction

  function automatic longint rotate_sine(input longint a);
    longint x, y, z, nx, ny;
    x = gain_inverse(); y = 0;
    if (a < 0) a = 0;
    if (a > PI_Q30) a = PI_Q30;
    if (a > HPI_Q30) a = PI_Q30 - a;
    z = a;
    for (int i = 0; i < 16; i++) begin
      if (z >= 0) begin
        nx = x - shr_floor(y, i); ny = y + shr_floor(x, i); z -= ATAN_Q30[i];
      end else begin
        nx = x + shr_floor(y, i); ny = y - shr_floor(x, i); z += ATAN_Q30[i];
      end
      x = nx; y = ny;
    end
    if (y < 0) y = 0;
    if (y > ONE_Q30) y = ONE_Q30;
    return y;
  endfunction

  function automatic quat_res_t slerp_unit(input logic signed [15:0] qa [4],
                                           input logic signed [15:0] qb [4],
                                           input logic [16:0] fr,
                                           input logic [14:0] thr);
    quat_res_t       res;
    longint          f, c, absc, k0, k1, c30, s, ang, sn0, sn1;
    longint          v [4];
    longint unsigned m, len2, len, mag, q;
    int              sh;
    f = fr > 65536 ? 65536 : fr;
    c = 0;
    for (int i = 0; i < 4; i++) c += longint'(qa[i]) * longint'(qb[i]);
    absc = c < 0 ? -c : c;
    k0 = 65536 - f;
    k1 = f;
    if (absc <= longint'(thr) * 16384) begin
      c30 = c <<< 2;
      if (c30 > -ONE_Q30 && c30 < ONE_Q30) begin
        s   = longint'(int_root((64'd1 << 60) - longint'(c30 * c30)));
        ang = vector_angle(s, c30);
        sn0 = rotate_sine((ang * (65536 - f)) >>> 16);
        sn1 = rotate_sine((ang * f) >>> 16);
        k0  = (sn0 * 65536) / s;
        k1  = (sn1 * 65536) / s;
      end
    end
    m = 0;
    for (int i = 0; i < 4; i++) begin
      v[i] = k0 * qa[i] + k1 * qb[i];
      mag  = v[i] < 0 ? -v[i] : v[i];
      if (mag > m) m = mag;
    end
    sh = 0;
    while ((m >> sh) >= (64'd1 << 30)) sh++;
    len2 = 0;
    for (int i = 0; i < 4; i++) begin
      v[i] = v[i] >>> sh;
      len2 += longint'(v[i] * v[i]);
    end
    len = int_root(len2);
    res.deg = (sh == 0 && len < 65536);
    for (int i = 0; i < 4; i++) begin
      logic signed [15:0] o;
      o = 0;
      if (!res.deg) begin
        mag = v[i] < 0 ? -v[i] : v[i];
        q   = ((mag << 14) + len / 2) / len;
        if (v[i] < 0) o = (q > 32768) ? -16'sd32768 : -$signed(q[15:0]);
        else          o = (q > 32767) ? 16'sd32767 : q[15:0];
      end
      case (i)
        0: res.w = o;
        1: res.x = o;
        2: res.y = o;
        default: res.z = o;
      endcase
    end
    return res;
  endfunction

  class slerp_scoreboard;
    quat_res_t pending [$];
    int        mismatches;

    function void note_input(quat_res_t r);
      pending.push_back(r);
    endfunction

    function void check_word(quat_res_t got);
      quat_res_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word w=%0d", got.w);
        return;
      end
      want = pending.pop_front();
      if (got.w !== want.w || got.x !== want.x || got.y !== want.y ||
          got.z !== want.z || got.deg !== want.deg) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected %0d %0d %0d %0d deg %0b, got %0d %0d %0d %0d deg %0b",
                   want.w, want.x, want.y, want.z, want.deg,
                   got.w, got.x, got.y, got.z, got.deg);
      end
    endfunction
  endclass

  logic clk_i = 1'b0, rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic [THR_W-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0, out_stall_i = 1'b0;
  logic signed [15:0] a_w_i = 0, a_x_i = 0, a_y_i = 0, a_z_i = 0;
  logic signed [15:0] b_w_i = 0, b_x_i = 0, b_y_i = 0, b_z_i = 0;
  logic [FRAC_W-1:0] frac_i = '0;
  logic cfg_ready_o, in_stall_o, out_valid_o, degenerate_o;
  logic signed [15:0] out_w_o, out_x_o, out_y_o, out_z_o;

  quaternion_slerp_normalize dut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  slerp_scoreboard sb = new();
  logic [14:0] thr_now = THR_RESET;
  bit          quiet = 1'b0;
  int          idle_cycles = 0;

  // Result side: random stalls outside the quiet phase, checking at every accepted word.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_word('{out_w_o, out_x_o, out_y_o, out_z_o, degenerate_o});
    out_stall_i <= quiet ? 1'b0 : ($urandom_range(99) < 23);
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_MAX) begin
      $display("quaternion_slerp_normalize_tb: FAIL");
      $finish;
    end
  end

  task automatic write_threshold(input logic [14:0] val);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    thr_now = val;
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk_i);
  endtask

  task automatic send_pair(input logic signed [15:0] qa [4],
                           input logic signed [15:0] qb [4],
                           input logic [16:0] fr);
    if (!quiet) while ($urandom_range(99) < 23) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    {a_w_i, a_x_i, a_y_i, a_z_i} <= {qa[0], qa[1], qa[2], qa[3]};
    {b_w_i, b_x_i, b_y_i, b_z_i} <= {qb[0], qb[1], qb[2], qb[3]};
    frac_i <= fr;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_input(slerp_unit(qa, qb, fr, thr_now));
  endtask

  function automatic logic signed [15:0] rand_comp(input int mode);
    case (mode)
      0: return 16'($urandom);
      1: return 16'($urandom_range(16384) - 8192);
      default: return 16'($urandom_range(3) - 2);
    endcase
  endfunction

  task automatic send_random();
    logic signed [15:0] qa [4], qb [4];
    logic [16:0] fr;
    int mode;
    mode = $urandom_range(9) < 6 ? 1 : ($urandom_range(1) ? 0 : 2);
    for (int i = 0; i < 4; i++) begin
      qa[i] = rand_comp(mode);
      // Often make B close to A so the linear path is hit.
      qb[i] = $urandom_range(2) == 0 ? 16'(qa[i] + $signed($urandom_range(600)) - 300)
                                      : rand_comp(mode);
    end
    case ($urandom_range(9))
      0: fr = 0;
      1: fr = 65536;
      2: fr = 17'(17'h1FFFF - $urandom_range(3));
      default: fr = 17'($urandom_range(65536));
    endcase
    send_pair(qa, qb, fr);
  endtask

  initial begin
    logic signed [15:0] ua [4], ub [4];
    logic [14:0] thr_list [4];
    thr_list = '{15'd0, 15'd16384, 15'h7FFF, 15'd5000};
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed words: unit and extreme components, identical, opposite and
    // orthogonal pairs, fractions at 0, 1 and above 1, and a zero sum.
    ua = '{16384, 0, 0, 0}; ub = '{0, 16384, 0, 0};
    send_pair(ua, ub, 0); send_pair(ua, ub, 32768); send_pair(ua, ub, 65536);
    send_pair(ua, ub, 17'h1FFFF);
    send_pair(ua, ua, 20000);
    ub = '{-16384, 0, 0, 0};
    send_pair(ua, ub, 32768);
    ua = '{0, 0, 0, 0}; send_pair(ua, ua, 1000);
    ua = '{1, 0, 0, 0}; ub = '{0, 0, 0, 1}; send_pair(ua, ub, 40000);
    ua = '{-32768, -32768, -32768, -32768}; ub = '{32767, 32767, 32767, 32767};
    send_pair(ua, ub, 12345); send_pair(ua, ua, 50000);
    ub = '{-32768, 32767, -32768, 32767}; send_pair(ua, ub, 65535);
    ua = '{11585, 11585, 0, 0}; ub = '{11585, 0, 11585, 0};
    send_pair(ua, ub, 32768);
    ua = '{16384, 0, 0, 0}; ub = '{-16384, 1, 0, 0}; send_pair(ua, ub, 1);

    // Hold off until the pipeline is empty.
    in_valid_i <= 1'b0;
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      if (ph > 0) begin
        in_valid_i <= 1'b0;
        drain();
        repeat (LATENCY + 10) @(posedge clk_i);
        write_threshold(thr_list[ph - 1]);
        send_pair(ua, ub, 32768);
      end
      for (int n = 0; n < N_RANDOM / 5; n++) send_random();
      if (ph == 2) begin
        quiet = 1'b1;
        for (int n = 0; n < N_QUIET; n++) send_random();
        quiet = 1'b0;
      end
    end
    in_valid_i <= 1'b0;
    drain();
    repeat (LATENCY + 20) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending.size() == 0)
      $display("quaternion_slerp_normalize_tb: PASS");
    else
      $display("quaternion_slerp_normalize_tb: FAIL");
    $finish;
  end
endmodule

### filelist.f
design/qsn_pkg.sv
design/quaternion_slerp_normalize.sv
sim/quaternion_slerp_normalize_tb.sv
